// ===== hw/rtl/omm_pkg.sv =====
// Shared types, codes and constants of the output mixing matrix.
package omm_pkg;

    localparam int OUTPUT_COUNT_DEFAULT = 8;

    localparam int WEIGHT_W   = 8;
    localparam int CMD_W      = 16;
    localparam int PULSE_W    = 16;
    localparam int THROTTLE_W = 8;
    localparam int TAP_COUNT  = 5;

    // Signed difference of two pulse widths, also wide enough for the offset step.
    localparam int SPAN_W = PULSE_W + 1;
    localparam int PROD_W = SPAN_W + WEIGHT_W;
    // Worst-case row sum stays below 2**25 in magnitude.
    localparam int ACC_W  = 26;
    localparam int MIX_SHIFT = 5;
    localparam int MIX_W  = ACC_W - MIX_SHIFT + 1;

    // Offset step is span * 32 / 50, done as span * ceil(2**21 * 0.64) >> 21.
    // The excess of the reciprocal stays below 1/25 over the whole 16-bit span.
    localparam int             STEP_SHIFT = 21;
    localparam int             RECIP_W    = 21;
    localparam logic [RECIP_W-1:0] STEP_RECIP = 21'd1342178;

    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_WRITE    = 2'd0;
    localparam opcode_t OP_RUN_IDLE = 2'd1;
    localparam opcode_t OP_RUN_LIVE = 2'd2;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_MOTOR = 2'd1;
    localparam kind_t KIND_SERVO = 2'd2;

    typedef logic [2:0] reg_index_t;
    localparam reg_index_t REG_PULSE_LOW    = 3'd0;
    localparam reg_index_t REG_PULSE_MID    = 3'd1;
    localparam reg_index_t REG_PULSE_MIN    = 3'd2;
    localparam reg_index_t REG_PULSE_MAX    = 3'd3;
    localparam reg_index_t REG_MIN_THROTTLE = 3'd4;

    localparam logic [PULSE_W-1:0]    PULSE_LOW_RESET    = 16'd1000;
    localparam logic [PULSE_W-1:0]    PULSE_MID_RESET    = 16'd1500;
    localparam logic [PULSE_W-1:0]    PULSE_MIN_RESET    = 16'd900;
    localparam logic [PULSE_W-1:0]    PULSE_MAX_RESET    = 16'd2100;
    localparam logic [THROTTLE_W-1:0] MIN_THROTTLE_RESET = 8'd0;

    typedef logic [2:0] tap_t;
    localparam tap_t TAP_STEP = 3'd4;

    // Weights in order roll, pitch, yaw, lift, offset.
    typedef struct packed {
        logic [TAP_COUNT-1:0][WEIGHT_W-1:0] weights;
        kind_t                              kind;
    } row_t;

    typedef struct packed {
        logic en;
        logic first;
    } mac_ctl_t;

    typedef struct packed {
        logic [PULSE_W-1:0] low;
        logic [PULSE_W-1:0] min;
        logic [PULSE_W-1:0] max;
    } clamp_cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_MAC,
        ST_OUT
    } state_t;

endpackage

// ===== hw/rtl/output_mixing_matrix_core.sv =====
// Output mixing matrix: row table, sequencer and output register.
//
// Input stream (s_axis): tuser carries the opcode. A write transaction stores
// the weights and kind of one row; a write to a row index of OUTPUT_COUNT or more and
// the spare opcode are dropped. A compute transaction carries the four
// commands and yields one result per row, in row order, on m_axis with
// tlast on the final row.
// Configuration (cfg_*): always ready, one register per transaction; write
// only while no compute transaction is in flight.
// Sequence: a compute transaction first takes a setup step for the offset
// step, then per row a multiply-accumulate step for each of the four
// commands and the offset on the single shared multiply-accumulate unit
// and a final step to clamp, gate and load the output register.
// s_axis_tready stays low until the last row has been loaded.
// A stalled receiver holds the output register; the sequencer waits in its
// output step until the register frees up, so nothing is lost.
// Reset clears the row table (all rows unused, weights zero), loads the
// default pulse settings and empties the output register.
module output_mixing_matrix_core
    import omm_pkg::*;
#(
    parameter int OUTPUT_COUNT = OUTPUT_COUNT_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [2:0] row_index, [10:3] roll_weight, [18:11] pitch_weight,
    // [26:19] yaw_weight, [34:27] lift_weight, [42:35] offset_weight,
    // [44:43] row_kind, [60:45] roll_cmd, [76:61] pitch_cmd,
    // [92:77] yaw_cmd, [108:93] lift_cmd, [111:109] zero
    input  logic [111:0] s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] channel, [18:3] pulse_width, [23:19] zero
    output logic [23:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  reg_index_t   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int ROW_W = (OUTPUT_COUNT > 1) ? $clog2(OUTPUT_COUNT) : 1;

    // Configuration registers.
    logic [PULSE_W-1:0]    pulse_low_reg;
    logic [PULSE_W-1:0]    pulse_mid_reg;
    logic [PULSE_W-1:0]    pulse_min_reg;
    logic [PULSE_W-1:0]    pulse_max_reg;
    logic [THROTTLE_W-1:0] min_throttle_reg;

    // Fields of the input transaction.
    opcode_t                   in_op;
    logic [2:0]                in_row_index;
    row_t                      in_row;
    logic [3:0][CMD_W-1:0]     in_cmds;
    logic                      in_accept;
    logic                      in_run;

    // Sequencer state.
    state_t                    state_reg;
    state_t                    state_next;
    logic [ROW_W-1:0]          row_reg;
    tap_t                      tap_reg;
    logic                      live_reg;
    logic [3:0][CMD_W-1:0]     cmd_reg;
    logic signed [SPAN_W-1:0]  span_reg;
    logic [PULSE_W-1:0]        span_mag_reg;
    logic                      span_neg_reg;
    logic signed [SPAN_W-1:0]  step_reg;
    logic [PULSE_W-1:0]        floor_reg;

    logic signed [SPAN_W-1:0]  span_full;
    logic [SPAN_W-1:0]         floor_sum;
    logic [PULSE_W+RECIP_W-1:0] step_prod;
    logic [PULSE_W-1:0]        step_mag;
    logic signed [SPAN_W-1:0]  step_next;

    // Datapath links.
    row_t                      cur_row;
    mac_ctl_t                  mac_ctl;
    logic signed [SPAN_W-1:0]  mac_bias;
    logic signed [SPAN_W-1:0]  mac_opnd;
    logic signed [WEIGHT_W-1:0] mac_weight;
    logic signed [ACC_W-1:0]   acc;
    clamp_cfg_t                clamp_cfg;
    logic [PULSE_W-1:0]        row_pulse;

    // Output register.
    logic                      out_valid_reg;
    logic [2:0]                out_channel_reg;
    logic [PULSE_W-1:0]        out_pulse_reg;
    logic                      out_last_reg;
    logic                      out_free;
    logic                      out_load;
    logic                      row_is_last;
    logic [4:0]                row_ext;

    logic                      wr_en;
    logic [ROW_W-1:0]          wr_idx;

    assign in_op              = s_axis_tuser;
    assign in_row_index       = s_axis_tdata[2:0];
    assign in_row.weights[0]  = s_axis_tdata[10:3];
    assign in_row.weights[1]  = s_axis_tdata[18:11];
    assign in_row.weights[2]  = s_axis_tdata[26:19];
    assign in_row.weights[3]  = s_axis_tdata[34:27];
    assign in_row.weights[4]  = s_axis_tdata[42:35];
    assign in_row.kind        = s_axis_tdata[44:43];
    assign in_cmds[0]         = s_axis_tdata[60:45];
    assign in_cmds[1]         = s_axis_tdata[76:61];
    assign in_cmds[2]         = s_axis_tdata[92:77];
    assign in_cmds[3]         = s_axis_tdata[108:93];

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_run    = (in_op == OP_RUN_IDLE) || (in_op == OP_RUN_LIVE);
    assign wr_en     = in_accept && (in_op == OP_WRITE)
                       && (32'(in_row_index) < OUTPUT_COUNT);
    assign wr_idx    = ROW_W'(in_row_index);

    // Configuration port.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_low_reg    <= PULSE_LOW_RESET;
            pulse_mid_reg    <= PULSE_MID_RESET;
            pulse_min_reg    <= PULSE_MIN_RESET;
            pulse_max_reg    <= PULSE_MAX_RESET;
            min_throttle_reg <= MIN_THROTTLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PULSE_LOW:    pulse_low_reg    <= cfg_data;
                REG_PULSE_MID:    pulse_mid_reg    <= cfg_data;
                REG_PULSE_MIN:    pulse_min_reg    <= cfg_data;
                REG_PULSE_MAX:    pulse_max_reg    <= cfg_data;
                REG_MIN_THROTTLE: min_throttle_reg <= cfg_data[THROTTLE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Per-run values taken when the compute transaction is accepted.
    assign span_full = $signed({1'b0, pulse_mid_reg}) - $signed({1'b0, pulse_low_reg});
    assign floor_sum = {1'b0, pulse_low_reg}
                       + SPAN_W'({min_throttle_reg, 3'b000})
                       + SPAN_W'({min_throttle_reg, 1'b0});

    // Offset step magnitude through the reciprocal, sign restored afterwards.
    assign step_prod = span_mag_reg * STEP_RECIP;
    assign step_mag  = step_prod[STEP_SHIFT +: PULSE_W];
    assign step_next = span_neg_reg ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});

    always_ff @(posedge clk)
    begin
        if (in_accept && in_run)
        begin
            live_reg     <= (in_op == OP_RUN_LIVE);
            cmd_reg      <= in_cmds;
            span_reg     <= span_full;
            span_neg_reg <= span_full[SPAN_W-1];
            span_mag_reg <= span_full[SPAN_W-1] ? PULSE_W'(-span_full)
                                                : span_full[PULSE_W-1:0];
            floor_reg    <= floor_sum[SPAN_W-1] ? {PULSE_W{1'b1}} : floor_sum[PULSE_W-1:0];
        end
        if (state_reg == ST_PREP)
        begin
            step_reg <= step_next;
        end
    end

    assign row_is_last = (row_reg == ROW_W'(OUTPUT_COUNT - 1));
    assign out_free    = !out_valid_reg || m_axis_tready;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && in_run)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (tap_reg == TAP_STEP)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = row_is_last ? ST_IDLE : ST_MAC;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        s_axis_tready = 1'b0;
        mac_ctl       = '0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_MAC:
            begin
                mac_ctl.en    = 1'b1;
                mac_ctl.first = (tap_reg == '0);
            end
            ST_OUT:
            begin
                out_load = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_PREP:
                begin
                    row_reg <= '0;
                    tap_reg <= '0;
                end
                ST_MAC:
                begin
                    tap_reg <= (tap_reg == TAP_STEP) ? '0 : tap_reg + 3'd1;
                end
                ST_OUT:
                begin
                    if (out_free && !row_is_last)
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
                default:
                begin
                    tap_reg <= '0;
                end
            endcase
        end
    end

    omm_row_table #(
        .OUTPUT_COUNT (OUTPUT_COUNT),
        .ROW_W        (ROW_W)
    ) u_row_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (wr_en),
        .wr_idx (wr_idx),
        .wr_row (in_row),
        .rd_idx (row_reg),
        .rd_row (cur_row)
    );

    // Operand selection for the shared multiply-accumulate unit.
    always_comb
    begin
        case (tap_reg)
            3'd0:    mac_opnd = SPAN_W'($signed(cmd_reg[0]));
            3'd1:    mac_opnd = SPAN_W'($signed(cmd_reg[1]));
            3'd2:    mac_opnd = SPAN_W'($signed(cmd_reg[2]));
            3'd3:    mac_opnd = SPAN_W'($signed(cmd_reg[3]));
            default: mac_opnd = step_reg;
        endcase
    end

    assign mac_weight = (tap_reg == TAP_STEP) ? $signed(cur_row.weights[4])
                                              : $signed(cur_row.weights[tap_reg[1:0]]);
    assign mac_bias   = (cur_row.kind == KIND_SERVO) ? span_reg : '0;

    omm_mac u_mac (
        .clk    (clk),
        .ctl    (mac_ctl),
        .bias   (mac_bias),
        .opnd   (mac_opnd),
        .weight (mac_weight),
        .acc    (acc)
    );

    assign clamp_cfg.low = pulse_low_reg;
    assign clamp_cfg.min = pulse_min_reg;
    assign clamp_cfg.max = pulse_max_reg;

    omm_post u_post (
        .acc         (acc),
        .cfg         (clamp_cfg),
        .floor_pulse (floor_reg),
        .kind        (cur_row.kind),
        .live        (live_reg),
        .pulse       (row_pulse)
    );

    // Output register.
    assign row_ext = 5'(row_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_channel_reg <= row_ext[2:0];
            out_pulse_reg   <= row_pulse;
            out_last_reg    <= row_is_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000, out_pulse_reg, out_channel_reg};
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTH
    a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[2:0] == 3'(OUTPUT_COUNT - 1))
        else $error("tlast on a channel other than the final row");

    a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tap_reg <= TAP_STEP)
        else $error("tap counter ran past the offset tap");

    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && in_run |=> state_reg == ST_PREP && row_reg == $past(row_reg))
        else $error("compute transaction did not start the setup step");

    a_load_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> state_reg == ST_OUT && $past(state_reg) != ST_IDLE)
        else $error("output register loaded outside the output step");
`endif

endmodule

// ===== hw/rtl/omm_row_table.sv =====
// Row table: one weight set and kind per output row, cleared at reset.
module omm_row_table
    import omm_pkg::*;
#(
    parameter int OUTPUT_COUNT = OUTPUT_COUNT_DEFAULT,
    parameter int ROW_W = (OUTPUT_COUNT > 1) ? $clog2(OUTPUT_COUNT) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [ROW_W-1:0] wr_idx,
    input  row_t             wr_row,
    input  logic [ROW_W-1:0] rd_idx,
    output row_t             rd_row
);

    row_t rows_reg [OUTPUT_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < OUTPUT_COUNT; i++)
            begin
                rows_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            rows_reg[wr_idx] <= wr_row;
        end
    end

    assign rd_row = rows_reg[rd_idx];

endmodule

// ===== hw/rtl/omm_mac.sv =====
// Shared multiply-accumulate unit that builds one row sum from the bias and the products.
module omm_mac
    import omm_pkg::*;
(
    input  logic                     clk,
    input  mac_ctl_t                 ctl,
    input  logic signed [SPAN_W-1:0] bias,
    input  logic signed [SPAN_W-1:0] opnd,
    input  logic signed [WEIGHT_W-1:0] weight,
    output logic signed [ACC_W-1:0]  acc
);

    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    assign prod = opnd * weight;

    always_comb
    begin
        if (ctl.first)
        begin
            acc_next = ACC_W'(bias) + ACC_W'(prod);
        end
        else
        begin
            acc_next = acc_reg + ACC_W'(prod);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== hw/rtl/omm_post.sv =====
// Scaling, clamping and gating of one finished row sum into a pulse width.
module omm_post
    import omm_pkg::*;
(
    input  logic signed [ACC_W-1:0] acc,
    input  clamp_cfg_t              cfg,
    input  logic [PULSE_W-1:0]      floor_pulse,
    input  kind_t                   kind,
    input  logic                    live,
    output logic [PULSE_W-1:0]      pulse
);

    logic signed [MIX_W-1:0] shifted;
    logic signed [MIX_W-1:0] mix;
    logic signed [MIX_W-1:0] lo_ext;
    logic signed [MIX_W-1:0] hi_ext;
    logic [PULSE_W-1:0]      clamped;

    // An arithmetic shift of a two's complement sum rounds toward minus infinity.
    assign shifted = MIX_W'($signed(acc[ACC_W-1:MIX_SHIFT]));
    assign mix     = shifted + $signed({{(MIX_W-PULSE_W){1'b0}}, cfg.low});
    assign lo_ext  = $signed({{(MIX_W-PULSE_W){1'b0}}, cfg.min});
    assign hi_ext  = $signed({{(MIX_W-PULSE_W){1'b0}}, cfg.max});

    always_comb
    begin
        if (mix < lo_ext)
        begin
            clamped = cfg.min;
        end
        else if (mix > hi_ext)
        begin
            clamped = cfg.max;
        end
        else
        begin
            clamped = mix[PULSE_W-1:0];
        end
    end

    always_comb
    begin
        case (kind)
            KIND_SERVO:
            begin
                pulse = clamped;
            end
            KIND_MOTOR:
            begin
                if (!live)
                begin
                    pulse = cfg.low;
                end
                else if (clamped > floor_pulse)
                begin
                    pulse = clamped;
                end
                else
                begin
                    pulse = floor_pulse;
                end
            end
            default:
            begin
                pulse = '0;
            end
        endcase
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the output mixing matrix core with a built-in mixer predictor.
module testbench;
    import omm_pkg::*;

    localparam int ROWS          = 8;
    localparam int SETTLE_CYCLES = 60;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 100;
    localparam int RANDOM_PHASES = 6;
    localparam int RANDOM_ITEMS  = 64;

    localparam opcode_t OP_SPARE    = 2'd3;
    localparam kind_t   KIND_UNUSED = 2'd0;
    localparam kind_t   KIND_SPARE  = 2'd3;

    localparam reg_index_t REG_ORDER [5] = '{REG_PULSE_LOW, REG_PULSE_MID, REG_PULSE_MIN,
                                             REG_PULSE_MAX, REG_MIN_THROTTLE};

    // Register settings per phase: pulse_low, pulse_mid, pulse_min, pulse_max, min_throttle.
    // The last phase draws its settings at random.
    localparam logic [15:0] PHASE_REGS [5][5] = '{
        '{16'd1000,  16'd1500,  16'd1000, 16'd2000,  16'd10},
        '{16'd0,     16'hFFFF,  16'd0,    16'hFFFF,  16'd255},
        '{16'hFFFF,  16'd0,     16'd0,    16'hFFFF,  16'd255},
        '{16'd1200,  16'd1500,  16'd3000, 16'd800,   16'd50},
        '{16'd0,     16'd0,     16'd0,    16'd0,     16'd0}
    };

    typedef struct packed {
        opcode_t                            op;
        logic [3:0][CMD_W-1:0]              cmd;   // roll in the low slot, lift in the high
        kind_t                              kind;
        logic [TAP_COUNT-1:0][WEIGHT_W-1:0] w;     // roll, pitch, yaw, lift, offset from bit 0
        logic [2:0]                         row;
    } mix_item_t;

    typedef struct packed {
        logic [2:0]         channel;
        logic [PULSE_W-1:0] pulse;
        logic               last;
    } pulse_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [23:0]  m_axis_tdata;
    logic         m_axis_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    reg_index_t   cfg_index = REG_PULSE_LOW;
    logic [15:0]  cfg_data = '0;

    // Predictor copy of the registers and the row table.
    logic [PULSE_W-1:0]                 cfg_low = PULSE_LOW_RESET;
    logic [PULSE_W-1:0]                 cfg_mid = PULSE_MID_RESET;
    logic [PULSE_W-1:0]                 cfg_min = PULSE_MIN_RESET;
    logic [PULSE_W-1:0]                 cfg_max = PULSE_MAX_RESET;
    logic [THROTTLE_W-1:0]              cfg_thr = MIN_THROTTLE_RESET;
    logic [TAP_COUNT-1:0][WEIGHT_W-1:0] row_w [ROWS] = '{default: '0};
    kind_t                              row_kind [ROWS] = '{default: KIND_UNUSED};

    mix_item_t pending_items [$];
    pulse_t    expected_pulses [$];
    mix_item_t offered;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int pulses_seen = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;
    bit failed = 1'b0;

    output_mixing_matrix_core #(
        .OUTPUT_COUNT(ROWS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Updates the row table or appends the pulse widths that a compute transaction produces.
    function automatic void mix_rows(mix_item_t it);
        longint span;
        longint step;
        longint acc;
        longint mix;
        longint floor_pw;
        logic [PULSE_W-1:0] pw;
        pulse_t exp_p;
        int r;
        int k;
        if (it.op == OP_WRITE)
        begin
            row_w[it.row] = it.w;
            row_kind[it.row] = it.kind;
        end
        else if (it.op == OP_RUN_IDLE || it.op == OP_RUN_LIVE)
        begin
            span = longint'(cfg_mid) - longint'(cfg_low);
            step = span * 32 / 50;
            floor_pw = longint'(cfg_low) + 10 * longint'(cfg_thr);
            if (floor_pw > 65535)
                floor_pw = 65535;
            for (r = 0; r < ROWS; r++)
            begin
                acc = (row_kind[r] == KIND_SERVO) ? span : 0;
                for (k = 0; k < 4; k++)
                    acc += longint'($signed(it.cmd[k])) * longint'($signed(row_w[r][k]));
                acc += step * longint'($signed(row_w[r][TAP_STEP]));
                // Arithmetic shift of a signed value rounds toward minus infinity.
                mix = longint'(cfg_low) + (acc >>> MIX_SHIFT);
                if (mix < longint'(cfg_min))
                    mix = longint'(cfg_min);
                else if (mix > longint'(cfg_max))
                    mix = longint'(cfg_max);
                if (row_kind[r] == KIND_SERVO)
                    pw = 16'(mix);
                else if (row_kind[r] == KIND_MOTOR)
                    pw = (it.op == OP_RUN_LIVE) ? 16'((mix > floor_pw) ? mix : floor_pw) : cfg_low;
                else
                    pw = '0;
                exp_p.channel = 3'(r);
                exp_p.pulse = pw;
                exp_p.last = (r == ROWS - 1);
                expected_pulses.push_back(exp_p);
            end
        end
    endfunction

    function automatic mix_item_t random_item();
        mix_item_t it;
        int pick;
        bit big;
        int k;
        pick = $urandom_range(99);
        big = ($urandom_range(2) == 0);
        it.op = (pick < 40) ? OP_WRITE : (pick < 55) ? OP_RUN_IDLE :
                (pick < 95) ? OP_RUN_LIVE : OP_SPARE;
        it.row = 3'($urandom);
        it.kind = 2'($urandom);
        // Small weights and commands keep many sums inside the clamp window.
        for (k = 0; k < TAP_COUNT; k++)
            it.w[k] = big ? 8'($urandom) : 8'($urandom_range(16) - 8);
        for (k = 0; k < 4; k++)
            it.cmd[k] = big ? 16'($urandom) : 16'($urandom_range(4000) - 2000);
        return it;
    endfunction

    function automatic mix_item_t make_row(logic [2:0] row, kind_t kind, logic [7:0] roll,
                                           logic [7:0] pitch, logic [7:0] yaw,
                                           logic [7:0] lift, logic [7:0] offs);
        mix_item_t it;
        it = '0;
        it.op = OP_WRITE;
        it.row = row;
        it.kind = kind;
        it.w = {offs, lift, yaw, pitch, roll};
        return it;
    endfunction

    function automatic mix_item_t make_run(opcode_t op, logic [15:0] roll, logic [15:0] pitch,
                                           logic [15:0] yaw, logic [15:0] lift);
        mix_item_t it;
        it = '0;
        it.op = op;
        it.cmd = {lift, yaw, pitch, roll};
        return it;
    endfunction

    task automatic write_reg(reg_index_t idx, logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PULSE_LOW:    cfg_low = value;
            REG_PULSE_MID:    cfg_mid = value;
            REG_PULSE_MIN:    cfg_min = value;
            REG_PULSE_MAX:    cfg_max = value;
            REG_MIN_THROTTLE: cfg_thr = value[7:0];
            default: ;
        endcase
    endtask

    // A row write yields nothing, so the block gets some extra cycles after the last pulse.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || s_axis_tvalid || expected_pulses.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : driver
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                mix_rows(offered);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {3'b000, offered.cmd, offered.kind, offered.w, offered.row};
                    s_axis_tuser <= offered.op;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        pulse_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                pulses_seen++;
                if (expected_pulses.size() == 0)
                begin
                    $error("unexpected transaction: channel %0d pulse_width %0d",
                           m_axis_tdata[2:0], m_axis_tdata[18:3]);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_pulses.pop_front();
                    if (m_axis_tdata[2:0] !== want.channel)
                    begin
                        $error("channel: expected %0d, actual %0d", want.channel,
                               m_axis_tdata[2:0]);
                        failed = 1'b1;
                    end
                    if (m_axis_tdata[18:3] !== want.pulse)
                    begin
                        $error("pulse_width: expected %0d, actual %0d", want.pulse,
                               m_axis_tdata[18:3]);
                        failed = 1'b1;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, m_axis_tlast);
                        failed = 1'b1;
                    end
                end
            end
            // One long hold-off lets the output register fill and the input stall.
            if (hold_left > 0)
                hold_left--;
            else if (!hold_done && pulses_seen >= HOLD_AFTER)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
            else
                quiet_cycles++;
        end
    end

    initial
    begin : stimulus
        mix_item_t   item;
        logic [15:0] values [5];
        int          ph;
        int          j;
        int          n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 28;
        recv_idle_pct = 45;

        // Directed part under the reset settings.
        pending_items.push_back(make_run(OP_RUN_LIVE, 16'd0, 16'd0, 16'd0, 16'd0));
        pending_items.push_back(make_row(3'd0, KIND_MOTOR, 8'd0, 8'd0, 8'd0, 8'h7F, 8'd0));
        pending_items.push_back(make_row(3'd1, KIND_SERVO, 8'h80, 8'd0, 8'd0, 8'd0, 8'd0));
        pending_items.push_back(make_row(3'd2, KIND_SPARE, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F));
        pending_items.push_back(make_row(3'd3, KIND_MOTOR, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80));
        pending_items.push_back(make_row(3'd4, KIND_MOTOR, 8'd0, 8'd0, 8'd0, 8'd0, 8'h80));
        pending_items.push_back(make_row(3'd5, KIND_SERVO, 8'd0, 8'd0, 8'd1, 8'd0, 8'h7F));
        pending_items.push_back(make_row(3'd6, KIND_MOTOR, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0));
        pending_items.push_back(make_row(3'd7, KIND_SERVO, 8'd0, 8'h7F, 8'd0, 8'hFF, 8'd0));
        pending_items.push_back(make_run(OP_RUN_IDLE, 16'd0, 16'd0, 16'd0, 16'h7FFF));
        pending_items.push_back(make_run(OP_RUN_LIVE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        pending_items.push_back(make_run(OP_RUN_LIVE, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        // A roll command of minus one leaves a sum of minus one in row 6, which must round down.
        pending_items.push_back(make_run(OP_RUN_LIVE, 16'hFFFF, 16'd0, 16'd0, 16'd0));
        item = random_item();
        item.op = OP_SPARE;
        pending_items.push_back(item);
        pending_items.push_back(make_run(OP_RUN_LIVE, 16'd50, 16'd0, 16'd0, 16'd100));
        pending_items.push_back(make_row(3'd0, KIND_UNUSED, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h33));
        pending_items.push_back(make_run(OP_RUN_LIVE, 16'd0, 16'd300, 16'hFED4, 16'd0));
        wait_idle();

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            for (j = 0; j < 5; j++)
                values[j] = (ph < 5) ? PHASE_REGS[ph][j] : 16'($urandom);
            for (j = 0; j < 5; j++)
                write_reg(REG_ORDER[j], values[j]);
            if (ph >= 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (ph >= 2)
            begin
                send_idle_pct = 45;
                recv_idle_pct = 28;
            end
            // Fill the whole table first, then mix writes, runs and spare opcodes.
            for (j = 0; j < ROWS; j++)
            begin
                item = random_item();
                item.op = OP_WRITE;
                item.row = 3'(j);
                pending_items.push_back(item);
            end
            n = 0;
            while (n < RANDOM_ITEMS)
            begin
                item = random_item();
                pending_items.push_back(item);
                if (item.op != OP_SPARE)
                    n++;
            end
            wait_idle();
        end

        if (failed || expected_pulses.size() != 0)
            $display("== FAIL ==");
        else
            $display("== PASS ==");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/omm_pkg.sv
hw/rtl/omm_row_table.sv
hw/rtl/omm_mac.sv
hw/rtl/omm_post.sv
hw/rtl/output_mixing_matrix_core.sv
verif/testbench.sv
